// File: src/msq_pkg.sv
// shared types and constants for the mode switchable stack/queue
// no dependencies; imported by msq_ctrl and mode_switchable_stack_queue
`default_nettype none

package msq_pkg;

  // ring size, must stay a power of two so ring wrap is a plain truncation
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned OPS_W  = 32;

  // command codes
  localparam logic [2:0] KIND_PUSH  = 3'd0;
  localparam logic [2:0] KIND_POP   = 3'd1;
  localparam logic [2:0] KIND_PEEK  = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MODE = 1'b1;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] push_value;
    logic [CNT_W-1:0]         position;
  } msq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_count;
    logic [OPS_W-1:0]         op_count;
  } msq_out_t;

  typedef struct packed {
    logic queue_mode;
    logic invert_mode;
  } msq_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } msq_mem_req_t;

endpackage

`default_nettype wire

// File: src/msq_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module msq_ram #(
  parameter int unsigned DATA_W = 64,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/msq_ctrl.sv
// ring pointer, fill count and op counter control, ram address generation
// and the result stage; depends on msq_pkg
`default_nettype none

module msq_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire msq_pkg::msq_in_t      in_i,
  input  wire msq_pkg::msq_cfg_t     cfg_i,
  output msq_pkg::msq_mem_req_t      mem_req_o,
  input  wire logic [msq_pkg::DATA_W-1:0] mem_rdata_i,
  output logic                       res_valid_o,
  output msq_pkg::msq_out_t          res_o
);
  import msq_pkg::*;

  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OPS_W-1:0]  ops_q, ops_d;

  logic              res_valid_q;
  logic              res_rd_q;
  logic [1:0]        res_status_q;
  logic [CNT_W-1:0]  res_fill_q;
  logic [OPS_W-1:0]  res_ops_q;

  logic [ADDR_W-1:0] cnt_lo, pos_lo;
  logic              full, empty, pos_bad;
  logic              rd_req;
  logic [1:0]        status;

  assign cnt_lo  = cnt_q[ADDR_W-1:0];
  assign pos_lo  = in_i.position[ADDR_W-1:0];
  assign full    = (cnt_q >= CNT_W'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign pos_bad = (in_i.position == '0) || (in_i.position > cnt_q);

  always_comb begin
    front_d         = front_q;
    cnt_d           = cnt_q;
    ops_d           = ops_q;
    rd_req          = 1'b0;
    status          = ST_OK;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = front_q + cnt_lo;
    mem_req_o.wdata = in_i.push_value;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = front_q;
    if (accept_i) begin
      unique case (in_i.kind)
        KIND_PUSH: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            mem_req_o.we = 1'b1;
            if (cfg_i.invert_mode) begin
              front_d         = front_q - 1'b1;
              mem_req_o.waddr = front_q - 1'b1;
            end
            cnt_d = cnt_q + 1'b1;
            ops_d = ops_q + 1'b1;
          end
        end
        KIND_POP, KIND_PEEK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_req       = 1'b1;
            mem_req_o.re = 1'b1;
            if (cfg_i.queue_mode) begin
              mem_req_o.raddr = front_q;
              if (in_i.kind == KIND_POP) begin
                front_d = front_q + 1'b1;
              end
            end else begin
              mem_req_o.raddr = front_q + cnt_lo - 1'b1;
            end
            if (in_i.kind == KIND_POP) begin
              cnt_d = cnt_q - 1'b1;
            end
          end
          if (in_i.kind == KIND_POP) begin
            ops_d = ops_q + 1'b1;
          end
        end
        KIND_CLEAR: begin
          cnt_d   = '0;
          front_d = '0;
          ops_d   = ops_q + 1'b1;
        end
        KIND_READ: begin
          if (pos_bad) begin
            status = ST_EMPTY;
          end else begin
            rd_req       = 1'b1;
            mem_req_o.re = 1'b1;
            if (cfg_i.queue_mode) begin
              mem_req_o.raddr = front_q + pos_lo - 1'b1;
            end else begin
              mem_req_o.raddr = front_q + cnt_lo - pos_lo;
            end
          end
        end
        default: begin
          // unused codes leave state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      cnt_q       <= '0;
      ops_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      ops_q       <= ops_d;
      res_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_rd_q     <= rd_req;
      res_status_q <= status;
      res_fill_q   <= cnt_d;
      res_ops_q    <= ops_d;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign res_o.read_value = res_rd_q ? mem_rdata_i : '0;
  assign res_o.status     = res_status_q;
  assign res_o.fill_count = res_fill_q;
  assign res_o.op_count   = res_ops_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fill count above ring depth");

  a_res_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> res_valid_q)
    else $error("accepted command produced no result beat");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_i.kind == KIND_CLEAR |=> cnt_q == '0 && front_q == '0)
    else $error("clear did not empty the ring");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_i.kind == KIND_PUSH && full |=> $stable(cnt_q) && $stable(ops_q))
    else $error("push on full ring changed state");

endmodule

`default_nettype wire

// File: src/mode_switchable_stack_queue.sv
// top level of the mode switchable stack/queue: config registers, control
// and cell ram; depends on msq_pkg, msq_ctrl and msq_ram
`default_nettype none

// A bounded ring of 1024 signed 64-bit cells used as a stack or a queue.
// A command is taken on any clock edge with start_i high; busy_o is never
// raised, so one command per cycle is sustained. Each command yields exactly
// one result beat, shown on res_o with res_valid_o high for a single cycle,
// in the cycle after the command was taken; the receiver cannot stall it and
// must take every beat. The rate is set by the cell ram: each command makes
// at most one access (a write for push, a read for pop, peek and depth
// read), and pointer, count and op counter update in the accept cycle, so
// a read in the next cycle already sees a push from the cycle before.
// The cell ram has no reset and no clearing pass; only held cells are read.
// Configuration (queue_mode at index 0, invert_mode at index 1) is written
// through cfg_we_i and should only change while no result is pending.
module mode_switchable_stack_queue (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // command channel
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire msq_pkg::msq_in_t                   in_i,
  // result channel
  output logic                                    res_valid_o,
  output msq_pkg::msq_out_t                       res_o,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [msq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic                               cfg_wdata_i
);
  import msq_pkg::*;

  logic         queue_mode_q;
  logic         invert_mode_q;
  msq_cfg_t     cfg;
  msq_mem_req_t mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic         accept;

  // no multi-cycle work, so commands are never held off
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // config registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_mode_q  <= 1'b0;
      invert_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_QUEUE_MODE:  queue_mode_q  <= cfg_wdata_i;
        CFG_INVERT_MODE: invert_mode_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.queue_mode  = queue_mode_q;
  assign cfg.invert_mode = invert_mode_q;

  // pointers, counters, address generation and result beat
  msq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // cell store, at most one access per command
  msq_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
